FILE: hw/rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, codes and constants of the character-LCD nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

    localparam int KIND_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int NIBBLE_W  = 4;
    localparam int HOLD_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;
    localparam int STEP_W    = 3;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CMD    = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_INIT   = 3'd2,
        KIND_CURSOR = 3'd3,
        KIND_GLYPH  = 3'd4
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON  = 1'd1;

    localparam logic [HOLD_W-1:0] HOLD_SHORT  = 13'd1;
    localparam logic [HOLD_W-1:0] HOLD_SETTLE = 13'd40;
    localparam logic [HOLD_W-1:0] HOLD_LONG   = 13'd4240;

    localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_SET_CGRAM  = 8'h40;

    localparam logic [STEP_W-1:0] INIT_STEP_WAKE  = 3'd0;
    localparam logic [STEP_W-1:0] INIT_STEP_CLEAR = 3'd4;
    localparam logic [STEP_W-1:0] INIT_STEP_LAST  = 3'd6;

    typedef struct packed {
        logic              rs;
        logic              init;
        logic [BYTE_W-1:0] value;
    } t_job;

    typedef enum logic [3:0] {
        PH_HI_ON  = 4'b0001,
        PH_HI_OFF = 4'b0010,
        PH_LO_ON  = 4'b0100,
        PH_LO_OFF = 4'b1000
    } t_phase;

    function automatic logic [BYTE_W-1:0] init_byte(input logic [STEP_W-1:0] step);
        logic [BYTE_W-1:0] v;
        unique case (step)
            3'd0:    v = 8'h30;
            3'd1:    v = 8'h30;
            3'd2:    v = 8'h28;
            3'd3:    v = 8'h08;
            3'd4:    v = 8'h01;
            3'd5:    v = 8'h06;
            default: v = CMD_DISPLAY_ON;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lcdnw_req_if.sv
// ----------------------------------------------------------------------------
// lcdnw_req_if
// Request channel: one beat carries one LCD request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdnw_req_if;
    logic                              valid;
    logic                              ready;
    logic [lcdnw_pkg::KIND_W-1:0]      kind;
    logic [lcdnw_pkg::BYTE_W-1:0]      byte_value;
    logic [7:0]                        column;
    logic [7:0]                        row;
    logic [7:0]                        glyph_slot;

    modport source (output valid, kind, byte_value, column, row, glyph_slot,
                    input ready);
    modport sink   (input valid, kind, byte_value, column, row, glyph_slot,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lcdnw_phase_if.sv
// ----------------------------------------------------------------------------
// lcdnw_phase_if
// Bus phase channel: one beat carries one phase of the 4-bit LCD bus.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdnw_phase_if;
    logic                              valid;
    logic                              ready;
    logic                              reg_select;
    logic                              enable;
    logic [lcdnw_pkg::NIBBLE_W-1:0]    nibble;
    logic [lcdnw_pkg::HOLD_W-1:0]      hold_us;
    logic                              last;

    modport source (output valid, reg_select, enable, nibble, hold_us, last,
                    input ready);
    modport sink   (input valid, reg_select, enable, nibble, hold_us, last,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front
// Accepts requests, clamps their arguments and turns them into byte jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lcdnw_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    lcdnw_req_if.sink                              i_req,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output lcdnw_pkg::t_job                        o_job
);
    import lcdnw_pkg::*;

    logic        r_cursor_on;
    logic        r_blink_on;
    logic        n_cursor_on;
    logic        n_blink_on;
    logic        kind_ok;
    logic [3:0]  col_idx;
    logic [2:0]  slot;
    t_job        job;

    always_comb begin
        n_cursor_on = r_cursor_on;
        n_blink_on  = r_blink_on;
        if (i_cfg_we && i_cfg_idx == CFG_CURSOR_ON) begin
            n_cursor_on = i_cfg_data[0];
        end
        if (i_cfg_we && i_cfg_idx == CFG_BLINK_ON) begin
            n_blink_on = i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_on <= 1'b0;
            r_blink_on  <= 1'b0;
        end else begin
            r_cursor_on <= n_cursor_on;
            r_blink_on  <= n_blink_on;
        end
    end

    always_comb begin
        if (i_req.column == 8'd0) begin
            col_idx = 4'd0;
        end else if (i_req.column > 8'd16) begin
            col_idx = 4'd15;
        end else begin
            col_idx = 4'(i_req.column - 8'd1);
        end
        slot = (i_req.glyph_slot > 8'd7) ? 3'd7 : i_req.glyph_slot[2:0];
    end

    always_comb begin
        kind_ok    = 1'b1;
        job.rs     = 1'b0;
        job.init   = 1'b0;
        job.value  = i_req.byte_value;
        unique case (i_req.kind)
            KIND_CMD: begin
            end
            KIND_DATA: begin
                job.rs = 1'b1;
            end
            KIND_INIT: begin
                job.init  = 1'b1;
                job.value = CMD_DISPLAY_ON | {6'd0, r_cursor_on, r_blink_on};
            end
            KIND_CURSOR: begin
                job.value = CMD_SET_DDRAM | {1'b0, i_req.row > 8'd1, 2'b00, col_idx};
            end
            KIND_GLYPH: begin
                job.value = CMD_SET_CGRAM | {2'b00, slot, 3'b000};
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full && kind_ok;
    assign o_job       = job;

endmodule

`default_nettype wire

FILE: hw/rtl/lcdnw_queue.sv
// ----------------------------------------------------------------------------
// lcdnw_queue
// Short job queue between the request front and the phase back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_queue #(
    parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire lcdnw_pkg::t_job    i_job,
    output logic                    o_full,
    output logic                    o_valid,
    output lcdnw_pkg::t_job         o_head,
    input  wire logic               i_pop
);
    import lcdnw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back
// Emits the head job's bytes as bus phases, one a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire lcdnw_pkg::t_job    i_q_head,
    output logic                    o_pop,
    lcdnw_phase_if.source           o_phase
);
    import lcdnw_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [STEP_W-1:0]     r_step;
    logic [STEP_W-1:0]     n_step;
    logic                  r_valid;
    logic                  n_valid;
    logic                  r_rs;
    logic                  r_en;
    logic [NIBBLE_W-1:0]   r_nib;
    logic [HOLD_W-1:0]     r_hold;
    logic                  r_last;

    logic                  advance;
    logic [BYTE_W-1:0]     cur_byte;
    logic                  long_wait;
    logic                  final_byte;
    logic                  en;
    logic [NIBBLE_W-1:0]   nib;
    logic [HOLD_W-1:0]     hold;
    logic                  last;

    assign advance = i_q_valid && (!r_valid || o_phase.ready);

    always_comb begin
        cur_byte   = (i_q_head.init && r_step != INIT_STEP_LAST) ? init_byte(r_step)
                                                                 : i_q_head.value;
        long_wait  = i_q_head.init &&
                     (r_step == INIT_STEP_WAKE || r_step == INIT_STEP_CLEAR);
        final_byte = !i_q_head.init || r_step == INIT_STEP_LAST;
    end

    always_comb begin
        en   = 1'b0;
        nib  = cur_byte[3:0];
        hold = HOLD_SHORT;
        last = 1'b0;
        unique case (r_phase)
            PH_HI_ON: begin
                en  = 1'b1;
                nib = cur_byte[7:4];
            end
            PH_HI_OFF: begin
                nib = cur_byte[7:4];
            end
            PH_LO_ON: begin
                en = 1'b1;
            end
            PH_LO_OFF: begin
                hold = long_wait ? HOLD_LONG : HOLD_SETTLE;
                last = final_byte;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_valid = r_valid;
        o_pop   = 1'b0;
        if (advance) begin
            n_valid = 1'b1;
            unique case (r_phase)
                PH_HI_ON:  n_phase = PH_HI_OFF;
                PH_HI_OFF: n_phase = PH_LO_ON;
                PH_LO_ON:  n_phase = PH_LO_OFF;
                default: begin
                    n_phase = PH_HI_ON;
                    if (final_byte) begin
                        n_step = '0;
                        o_pop  = 1'b1;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            endcase
        end else if (o_phase.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HI_ON;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rs   <= i_q_head.rs;
            r_en   <= en;
            r_nib  <= nib;
            r_hold <= hold;
            r_last <= last;
        end
    end

    assign o_phase.valid      = r_valid;
    assign o_phase.reg_select = r_rs;
    assign o_phase.enable     = r_en;
    assign o_phase.nibble     = r_nib;
    assign o_phase.hold_us    = r_hold;
    assign o_phase.last       = r_last;

endmodule

`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns character-LCD requests into enable/nibble phases of a 4-bit bus.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat
// i_req     in   one request: kind, byte_value, column, row, glyph_slot
// o_phase   out  one bus phase: reg_select, enable, nibble, hold_us, last
// i_cfg_*   in   register write: cursor_on (index 0), blink_on (index 1)
//
// One phase leaves per cycle while o_phase is ready and a job is queued.
// The back end's phase sequencer sets the rate; the job queue lets requests
// enter while earlier bytes are still being sent. Unused kinds are dropped.
// Reset clears the registers, the queue and the sequencer.
// A stalled o_phase holds its beat; i_req stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer #(
    parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lcdnw_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    lcdnw_req_if.sink                              i_req,
    lcdnw_phase_if.source                          o_phase
);
    import lcdnw_pkg::*;

    logic push;
    t_job push_job;
    logic full;
    logic q_valid;
    t_job q_head;
    logic pop;

    lcdnw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (pop)
    );

    lcdnw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_phase   (o_phase)
    );

endmodule

`default_nettype wire

FILE: tb/sv/lcdnw_phase_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcdnw_phase_checker
// Predicts and checks the bus phases of the nibble write sequencer.
// Watches the register port and the request channel, expands every accepted
// request into its expected enable/nibble phases, and compares each accepted
// phase beat field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lcdnw_phase_checker
    import lcdnw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    lcdnw_req_if                 i_req,
    lcdnw_phase_if               i_phase,
    output int                   o_outstanding,
    output int                   o_fail_count
);

    localparam int MAX_PRINTS = 40;

    localparam logic [BYTE_W-1:0] INIT_BYTES [6] = '{8'h30, 8'h30, 8'h28, 8'h08, 8'h01, 8'h06};

    typedef struct packed {
        logic                rs;
        logic                en;
        logic [NIBBLE_W-1:0] nib;
        logic [HOLD_W-1:0]   hold;
        logic                last;
    } t_bus_phase;

    t_bus_phase phase_q[$];
    logic       cursor_on;
    logic       blink_on;
    int         fail_total;

    initial begin
        cursor_on     = 1'b0;
        blink_on      = 1'b0;
        fail_total    = 0;
        o_outstanding = 0;
        o_fail_count  = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_total < MAX_PRINTS) begin
            $display("[%0t] phase mismatch: %s", $realtime, msg);
        end
        fail_total++;
    endtask

    task automatic queue_byte_phases(input logic [BYTE_W-1:0] value, input logic rs,
                                     input logic long_wait, input logic is_last);
        logic [NIBBLE_W-1:0] hi;
        logic [NIBBLE_W-1:0] lo;
        hi = value[7:4];
        lo = value[3:0];
        phase_q.push_back(t_bus_phase'{rs, 1'b1, hi, HOLD_SHORT, 1'b0});
        phase_q.push_back(t_bus_phase'{rs, 1'b0, hi, HOLD_SHORT, 1'b0});
        phase_q.push_back(t_bus_phase'{rs, 1'b1, lo, HOLD_SHORT, 1'b0});
        phase_q.push_back(t_bus_phase'{rs, 1'b0, lo,
                                       long_wait ? HOLD_LONG : HOLD_SETTLE, is_last});
    endtask

    task automatic predict_request(input logic [KIND_W-1:0] kind,
                                   input logic [BYTE_W-1:0] bv, input logic [7:0] col,
                                   input logic [7:0] row, input logic [7:0] slot);
        logic [BYTE_W-1:0] value;
        logic [7:0]        col_c;
        logic [7:0]        row_c;
        logic [7:0]        slot_c;
        case (kind)
            KIND_CMD:  queue_byte_phases(bv, 1'b0, 1'b0, 1'b1);
            KIND_DATA: queue_byte_phases(bv, 1'b1, 1'b0, 1'b1);
            KIND_INIT: begin
                for (int step = 0; step <= int'(INIT_STEP_LAST); step++) begin
                    if (step == int'(INIT_STEP_LAST)) begin
                        value = CMD_DISPLAY_ON | {6'b0, cursor_on, blink_on};
                    end else begin
                        value = INIT_BYTES[step];
                    end
                    queue_byte_phases(value, 1'b0,
                                      step == int'(INIT_STEP_WAKE) ||
                                      step == int'(INIT_STEP_CLEAR),
                                      step == int'(INIT_STEP_LAST));
                end
            end
            KIND_CURSOR: begin
                col_c = (col < 8'd1) ? 8'd1 : (col > 8'd16) ? 8'd16 : col;
                row_c = (row < 8'd1) ? 8'd1 : (row > 8'd2) ? 8'd2 : row;
                value = CMD_SET_DDRAM | ((row_c - 8'd1) << 6) | (col_c - 8'd1);
                queue_byte_phases(value, 1'b0, 1'b0, 1'b1);
            end
            KIND_GLYPH: begin
                slot_c = (slot > 8'd7) ? 8'd7 : slot;
                value  = CMD_SET_CGRAM | (slot_c << 3);
                queue_byte_phases(value, 1'b0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_phase();
        t_bus_phase got;
        t_bus_phase want;
        got = t_bus_phase'{i_phase.reg_select, i_phase.enable, i_phase.nibble,
                           i_phase.hold_us, i_phase.last};
        if (phase_q.size() == 0) begin
            report_mismatch($sformatf("beat with nothing expected (rs %0b en %0b nib %h)",
                                      got.rs, got.en, got.nib));
        end else begin
            want = phase_q.pop_front();
            if (got.rs !== want.rs)
                report_mismatch($sformatf("reg_select got %0b want %0b", got.rs, want.rs));
            if (got.en !== want.en)
                report_mismatch($sformatf("enable got %0b want %0b", got.en, want.en));
            if (got.nib !== want.nib)
                report_mismatch($sformatf("nibble got %h want %h", got.nib, want.nib));
            if (got.hold !== want.hold)
                report_mismatch($sformatf("hold_us got %0d want %0d", got.hold, want.hold));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_q.delete();
            cursor_on = 1'b0;
            blink_on  = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CURSOR_ON: cursor_on = i_cfg_data[0];
                    CFG_BLINK_ON:  blink_on  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.kind, i_req.byte_value, i_req.column, i_req.row,
                                i_req.glyph_slot);
            end
            if (i_phase.valid && i_phase.ready) begin
                check_phase();
            end
        end
        o_outstanding <= phase_q.size();
        o_fail_count  <= fail_total;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the character-LCD nibble write sequencer.
// Drives a directed set of requests, then random requests and well-formed
// glyph and text sequences under four display-mode settings, with bursty
// requests, a stalling phase sink and two long back-pressure stretches.
// ----------------------------------------------------------------------------
module tb_top;
    import lcdnw_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_STALL     = 300;
    localparam int ITEMS_PER_MODE = 75;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_PULSED,
        SINK_CHOKED
    } t_sink_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 long_stall_toggle;
    int                   outstanding;
    int                   fail_count;
    int                   items_sent;
    int                   burst_left;
    int                   cycle_count;

    lcdnw_req_if   req_bus ();
    lcdnw_phase_if phase_bus ();

    char_lcd_nibble_write_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_bus),
        .o_phase    (phase_bus)
    );

    lcdnw_phase_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_req         (req_bus),
        .i_phase       (phase_bus),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** char_lcd_nibble_write_sequencer: FAILED **");
        $finish;
    end

    // phase sink: stall on a changing pattern, hold off on request
    initial begin
        t_sink_mode sink_mode;
        int         mode_left;
        int         hold_left;
        logic       stall_seen;
        logic       rdy;
        sink_mode       = SINK_OPEN;
        mode_left       = 0;
        hold_left       = 0;
        stall_seen      = 1'b0;
        phase_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_seen != long_stall_toggle) begin
                stall_seen = long_stall_toggle;
                hold_left  = LONG_STALL;
            end
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(3, 0));
                mode_left = $urandom_range(120, 16);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (sink_mode)
                    SINK_OPEN:   rdy = 1'b1;
                    SINK_COIN:   rdy = 1'($urandom_range(1, 0));
                    SINK_PULSED: rdy = (mode_left % 3) != 0;
                    default:     rdy = ($urandom_range(3, 0) == 0);
                endcase
            end
            phase_bus.ready <= rdy;
        end
    end

    function automatic logic [7:0] pick_coord(input int span);
        if ($urandom_range(1, 0) != 0) return 8'($urandom_range(span, 0));
        return 8'($urandom_range(255, 0));
    endfunction

    // sender pacing: bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(4, 0);
            if (gap != 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(12, 1);
        end
    endtask

    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [7:0] bv,
                            input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] slot);
        req_bus.valid      <= 1'b1;
        req_bus.kind       <= kind;
        req_bus.byte_value <= bv;
        req_bus.column     <= col;
        req_bus.row        <= row;
        req_bus.glyph_slot <= slot;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        if (kind <= KIND_GLYPH) items_sent++;
        pace();
    endtask

    task automatic send_random_request();
        int                pick;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(99, 0);
        if (pick < 30)      kind = KIND_CMD;
        else if (pick < 60) kind = KIND_DATA;
        else if (pick < 75) kind = KIND_CURSOR;
        else if (pick < 87) kind = KIND_GLYPH;
        else if (pick < 93) kind = KIND_INIT;
        else                kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        send_req(kind, 8'($urandom_range(255, 0)), pick_coord(20), pick_coord(3),
                 pick_coord(10));
    endtask

    task automatic define_glyph();
        send_req(KIND_GLYPH, 8'($urandom_range(255, 0)), pick_coord(20), pick_coord(3),
                 pick_coord(10));
        repeat (8) begin
            send_req(KIND_DATA, 8'($urandom_range(255, 0)), pick_coord(20), pick_coord(3),
                     pick_coord(10));
        end
    endtask

    task automatic write_text_line();
        int n;
        n = $urandom_range(16, 1);
        send_req(KIND_CURSOR, 8'($urandom_range(255, 0)), pick_coord(20), pick_coord(3),
                 pick_coord(10));
        repeat (n) begin
            send_req(KIND_DATA, 8'($urandom_range(126, 32)), pick_coord(20), pick_coord(3),
                     pick_coord(10));
        end
    endtask

    task automatic run_random(input int target);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < target) begin
            pick = $urandom_range(9, 0);
            if (pick < 5)      send_random_request();
            else if (pick < 7) define_glyph();
            else if (pick < 9) write_text_line();
            else send_req(KIND_INIT, 8'($urandom_range(255, 0)), pick_coord(20),
                          pick_coord(3), pick_coord(10));
        end
    endtask

    task automatic wait_for_idle();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // drain, set the display mode, then open with an initialisation
    task automatic start_mode(input logic cursor, input logic blink, input logic squeeze);
        wait_for_idle();
        write_register(CFG_CURSOR_ON, cursor);
        write_register(CFG_BLINK_ON, blink);
        cfg_we <= 1'b0;
        if (squeeze) long_stall_toggle <= ~long_stall_toggle;
        send_req(KIND_INIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_CURSOR_ON;
        cfg_data           = 1'b0;
        long_stall_toggle  = 1'b0;
        items_sent         = 0;
        burst_left         = 0;
        req_bus.valid      = 1'b0;
        req_bus.kind       = KIND_CMD;
        req_bus.byte_value = 8'h00;
        req_bus.column     = 8'h00;
        req_bus.row        = 8'h00;
        req_bus.glyph_slot = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        start_mode(1'b0, 1'b0, 1'b0);
        send_req(KIND_CMD, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(KIND_CMD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(KIND_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(KIND_DATA, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(KIND_DATA, 8'h5A, 8'h10, 8'h01, 8'h03);
        send_req(KIND_CURSOR, 8'h00, 8'd0, 8'd0, 8'h00);
        send_req(KIND_CURSOR, 8'h00, 8'd1, 8'd1, 8'h00);
        send_req(KIND_CURSOR, 8'h00, 8'd16, 8'd2, 8'h00);
        send_req(KIND_CURSOR, 8'h00, 8'd17, 8'd3, 8'h00);
        send_req(KIND_CURSOR, 8'h00, 8'd255, 8'd255, 8'h00);
        send_req(KIND_CURSOR, 8'h00, 8'd5, 8'd0, 8'h00);
        send_req(KIND_GLYPH, 8'h00, 8'h00, 8'h00, 8'd0);
        send_req(KIND_GLYPH, 8'h00, 8'h00, 8'h00, 8'd7);
        send_req(KIND_GLYPH, 8'h00, 8'h00, 8'h00, 8'd8);
        send_req(KIND_GLYPH, 8'h00, 8'h00, 8'h00, 8'd255);
        send_req(KIND_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(KIND_UNUSED_LO + 3'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(KIND_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(ITEMS_PER_MODE);

        start_mode(1'b1, 1'b0, 1'b1);
        run_random(ITEMS_PER_MODE);
        start_mode(1'b0, 1'b1, 1'b0);
        run_random(ITEMS_PER_MODE);
        start_mode(1'b1, 1'b1, 1'b1);
        run_random(ITEMS_PER_MODE);

        wait_for_idle();
        if (fail_count == 0) begin
            $display("** char_lcd_nibble_write_sequencer: PASSED **");
        end else begin
            $display("** char_lcd_nibble_write_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

FILE: char_lcd_nibble_write_sequencer.f
hw/rtl/lcdnw_pkg.sv
hw/rtl/lcdnw_req_if.sv
hw/rtl/lcdnw_phase_if.sv
hw/rtl/lcdnw_front.sv
hw/rtl/lcdnw_queue.sv
hw/rtl/lcdnw_back.sv
hw/rtl/char_lcd_nibble_write_sequencer.sv
tb/sv/lcdnw_phase_checker.sv
tb/sv/tb_top.sv
